// File: hw/rtl/bzs_pkg.sv
// shared widths, constants and types of the cubic bezier sampler
package bzs_pkg;

    localparam int COORD_W             = 13;
    localparam int COEF_W              = 18;
    localparam int T_W                 = 17;
    localparam int FRAC_W              = 16;
    localparam int SAMPLE_W            = 21;
    localparam int SAMPLE_FRAC_W       = 8;
    localparam int STEP_W              = 12;
    localparam int LIMIT_W             = 2 * STEP_W;
    localparam int DIST_W              = 2 * (SAMPLE_W + 1) + 1;
    localparam int EVAL_STAGES         = 4;
    localparam int STEPS_DEFAULT       = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [STEP_W-1:0]  MAX_STEP_RESET = STEP_W'(10);
    localparam logic [LIMIT_W-1:0] LIMIT_SQ_RESET =
        LIMIT_W'(MAX_STEP_RESET) * LIMIT_W'(MAX_STEP_RESET);
    localparam logic [T_W-1:0]     T_ONE          = T_W'(1) << FRAC_W;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [1:0] {
        TOK_START,
        TOK_SAMPLE,
        TOK_END
    } tok_kind_t;

    // power-basis coefficients of one axis, plus the end points
    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        coord_t                   p0;
        coord_t                   p3;
    } axis_coef_t;

    typedef struct packed {
        axis_coef_t x;
        axis_coef_t y;
    } curve_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic      valid;
        tok_kind_t kind;
        coord_t    p0x;
        coord_t    p0y;
        coord_t    p3x;
        coord_t    p3y;
    } tag_t;

endpackage

// File: hw/rtl/bzs_front.sv
// front end: takes curve beats and turns control points into power-basis coefficients
module bzs_front
(
    input  logic                    in_valid,
    input  bzs_pkg::coord_t         start_x,
    input  bzs_pkg::coord_t         start_y,
    input  bzs_pkg::coord_t         ctrl1_x,
    input  bzs_pkg::coord_t         ctrl1_y,
    input  bzs_pkg::coord_t         ctrl2_x,
    input  bzs_pkg::coord_t         ctrl2_y,
    input  bzs_pkg::coord_t         end_x,
    input  bzs_pkg::coord_t         end_y,
    input  bzs_pkg::queue_status_t  q_status,
    output logic                    in_stall,
    output logic                    push,
    output bzs_pkg::curve_t         curve
);

    localparam int CW = bzs_pkg::COEF_W;

    logic signed [CW-1:0] x0, x1, x2, x3;
    logic signed [CW-1:0] y0, y1, y2, y3;
    logic signed [CW-1:0] x_d12, x_e, x_f;
    logic signed [CW-1:0] y_d12, y_e, y_f;

    assign x0 = CW'(start_x);
    assign x1 = CW'(ctrl1_x);
    assign x2 = CW'(ctrl2_x);
    assign x3 = CW'(end_x);
    assign y0 = CW'(start_y);
    assign y1 = CW'(ctrl1_y);
    assign y2 = CW'(ctrl2_y);
    assign y3 = CW'(end_y);

    // a = p3 - p0 + 3(p1 - p2), b = 3(p0 - 2p1 + p2), c = 3(p1 - p0)
    assign x_d12 = x1 - x2;
    assign x_e   = x0 - (x1 <<< 1) + x2;
    assign x_f   = x1 - x0;
    assign y_d12 = y1 - y2;
    assign y_e   = y0 - (y1 <<< 1) + y2;
    assign y_f   = y1 - y0;

    always_comb
    begin
        curve.x.a  = x3 - x0 + (x_d12 <<< 1) + x_d12;
        curve.x.b  = (x_e <<< 1) + x_e;
        curve.x.c  = (x_f <<< 1) + x_f;
        curve.x.p0 = start_x;
        curve.x.p3 = end_x;
        curve.y.a  = y3 - y0 + (y_d12 <<< 1) + y_d12;
        curve.y.b  = (y_e <<< 1) + y_e;
        curve.y.c  = (y_f <<< 1) + y_f;
        curve.y.p0 = start_y;
        curve.y.p3 = end_y;
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

endmodule

// File: hw/rtl/bzs_queue.sv
// short curve queue between front and back
module bzs_queue
#(
    parameter int DEPTH = bzs_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  bzs_pkg::curve_t        wr_data,
    input  logic                   pop,
    output bzs_pkg::curve_t        rd_data,
    output bzs_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bzs_pkg::curve_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: hw/rtl/bzs_eval.sv
// one axis of the curve: horner evaluation over four pipeline stages
module bzs_eval
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [bzs_pkg::T_W-1:0]              t,
    input  bzs_pkg::axis_coef_t                  coef,
    output logic signed [bzs_pkg::SAMPLE_W-1:0]  sample
);

    localparam int TW    = bzs_pkg::T_W;
    localparam int CW    = bzs_pkg::COEF_W;
    localparam int FW    = bzs_pkg::FRAC_W;
    localparam int V1_W  = CW + TW + 1;
    localparam int P2_W  = V1_W + TW + 1;
    localparam int V2_W  = 51;
    localparam int SPLIT = 26;
    localparam int HI_W  = V2_W - SPLIT;
    localparam int PP_W  = SPLIT + TW;
    localparam int V3_W  = 64;
    localparam int SHIFT = 3 * FW - bzs_pkg::SAMPLE_FRAC_W;

    logic signed [TW:0]                 ts0, ts1, ts2;
    logic signed [V1_W-1:0]             p1, v1_next, v1_reg;
    logic signed [P2_W-1:0]             p2;
    logic signed [V2_W-1:0]             v2_next, v2_reg;
    logic signed [HI_W-1:0]             hi_part;
    logic [PP_W-1:0]                    lo_next, lo_reg;
    logic signed [PP_W-1:0]             hi_next, hi_reg;
    logic signed [V3_W-1:0]             v3;
    logic [TW-1:0]                      t1_reg, t2_reg;
    logic signed [CW-1:0]               c1_reg;
    bzs_pkg::coord_t                    d1_reg, d2_reg, d3_reg;
    logic signed [bzs_pkg::SAMPLE_W-1:0] sample_reg;

    assign ts0 = $signed({1'b0, t});
    assign ts1 = $signed({1'b0, t1_reg});
    assign ts2 = $signed({1'b0, t2_reg});

    // stage 1: a*t + b*2^16
    assign p1      = coef.a * ts0;
    assign v1_next = p1 + (V1_W'(coef.b) <<< FW);

    // stage 2: v1*t + c*2^32
    assign p2      = v1_reg * ts1;
    assign v2_next = V2_W'(p2) + (V2_W'(c1_reg) <<< (2 * FW));

    // stage 3: v2*t as two partial products
    assign hi_part = $signed(v2_reg[V2_W-1:SPLIT]);
    assign lo_next = v2_reg[SPLIT-1:0] * t2_reg;
    assign hi_next = hi_part * ts2;

    // stage 4: recombine, add p0*2^48, floor to q13.8
    assign v3 = (V3_W'(hi_reg) <<< SPLIT) + $signed(V3_W'(lo_reg))
              + (V3_W'(d3_reg) <<< (3 * FW));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg     <= v1_next;
            t1_reg     <= t;
            c1_reg     <= coef.c;
            d1_reg     <= coef.p0;
            v2_reg     <= v2_next;
            t2_reg     <= t1_reg;
            d2_reg     <= d1_reg;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            d3_reg     <= d2_reg;
            sample_reg <= v3[SHIFT +: bzs_pkg::SAMPLE_W];
        end
    end

    assign sample = sample_reg;

endmodule

// File: hw/rtl/bzs_back.sv
// back end: step sequencer, evaluation lanes, distance filter and output register
module bzs_back
#(
    parameter int STEPS = bzs_pkg::STEPS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  bzs_pkg::curve_t               head,
    input  bzs_pkg::queue_status_t        q_status,
    output logic                          pop,
    input  logic [bzs_pkg::LIMIT_W-1:0]   limit_sq,
    input  logic                          out_stall,
    output logic                          out_valid,
    output bzs_pkg::coord_t               point_x,
    output bzs_pkg::coord_t               point_y,
    output logic                          last
);

    localparam int K_W    = $clog2(STEPS + 2);
    localparam int REM_W  = $clog2(STEPS) + 1;
    localparam int TW     = bzs_pkg::T_W;
    localparam int SW     = bzs_pkg::SAMPLE_W;
    localparam int SF     = bzs_pkg::SAMPLE_FRAC_W;
    localparam int DX_W   = SW + 1;
    localparam int DW     = bzs_pkg::DIST_W;
    localparam int NS     = bzs_pkg::EVAL_STAGES;
    localparam int T_STEP = (1 << bzs_pkg::FRAC_W) / STEPS;
    localparam int T_REM  = (1 << bzs_pkg::FRAC_W) % STEPS;
    localparam int LAST_K = STEPS + 1;

    function automatic bzs_pkg::coord_t to_coord(input logic signed [SW-1:0] s);
        bzs_pkg::coord_t q;
        begin
            q = s[SW-1:SF];
            if (s[SW-1] && (s[SF-1:0] != '0))
            begin
                q = q + 1'b1;
            end
            return q;
        end
    endfunction

    logic                       adv;
    logic                       issue;
    bzs_pkg::tok_kind_t         kind;
    logic [K_W-1:0]             k_reg, k_next;
    logic [TW-1:0]              t_reg, t_next;
    logic [REM_W-1:0]           rem_reg, rem_next, rem_sum;
    bzs_pkg::tag_t              tag_in, tag_out;
    bzs_pkg::tag_t              tag_reg [1:NS];
    logic signed [SW-1:0]       sample_x, sample_y;
    logic signed [SW-1:0]       ref_x_reg, ref_x_next, ref_y_reg, ref_y_next;
    logic signed [DX_W-1:0]     dx, dy;
    logic signed [2*DX_W-1:0]   sq_x, sq_y;
    logic [DW-1:0]              dist_sq, limit_ext;
    logic                       keep;
    logic                       emit;
    bzs_pkg::coord_t            x_sel, y_sel;
    logic                       last_sel;
    logic                       out_valid_reg;
    bzs_pkg::coord_t            point_x_reg, point_y_reg;
    logic                       last_reg;

    // whole back pipeline moves whenever the output register can take a beat
    assign adv   = !out_valid_reg || !out_stall;
    assign issue = adv && !q_status.empty;

    always_comb
    begin
        if (k_reg == '0)
        begin
            kind = bzs_pkg::TOK_START;
        end
        else if (k_reg == K_W'(LAST_K))
        begin
            kind = bzs_pkg::TOK_END;
        end
        else
        begin
            kind = bzs_pkg::TOK_SAMPLE;
        end
    end

    // t = floor(k * 2^16 / steps) kept as quotient plus running remainder
    assign rem_sum = rem_reg + REM_W'(T_REM);

    always_comb
    begin
        k_next   = k_reg;
        t_next   = t_reg;
        rem_next = rem_reg;
        if (issue)
        begin
            unique case (kind)
                bzs_pkg::TOK_START:
                begin
                    k_next   = k_reg + 1'b1;
                    t_next   = TW'(T_STEP);
                    rem_next = REM_W'(T_REM);
                end
                bzs_pkg::TOK_SAMPLE:
                begin
                    k_next = k_reg + 1'b1;
                    if (rem_sum >= REM_W'(STEPS))
                    begin
                        rem_next = rem_sum - REM_W'(STEPS);
                        t_next   = t_reg + TW'(T_STEP + 1);
                    end
                    else
                    begin
                        rem_next = rem_sum;
                        t_next   = t_reg + TW'(T_STEP);
                    end
                end
                bzs_pkg::TOK_END:
                begin
                    k_next = '0;
                end
                default:
                begin
                    k_next = '0;
                end
            endcase
        end
    end

    assign pop = issue && (kind == bzs_pkg::TOK_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= '0;
            t_reg   <= '0;
            rem_reg <= '0;
        end
        else
        begin
            k_reg   <= k_next;
            t_reg   <= t_next;
            rem_reg <= rem_next;
        end
    end

    bzs_eval u_eval_x
    (
        .clk    (clk),
        .en     (adv),
        .t      (t_reg),
        .coef   (head.x),
        .sample (sample_x)
    );

    bzs_eval u_eval_y
    (
        .clk    (clk),
        .en     (adv),
        .t      (t_reg),
        .coef   (head.y),
        .sample (sample_y)
    );

    always_comb
    begin
        tag_in.valid = issue;
        tag_in.kind  = kind;
        tag_in.p0x   = head.x.p0;
        tag_in.p0y   = head.y.p0;
        tag_in.p3x   = head.x.p3;
        tag_in.p3y   = head.y.p3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= NS; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            tag_reg[1] <= tag_in;
            for (int i = 2; i <= NS; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign tag_out = tag_reg[NS];

    // squared distance to the reference point against max_step^2 in q.16
    assign dx        = DX_W'(sample_x) - DX_W'(ref_x_reg);
    assign dy        = DX_W'(sample_y) - DX_W'(ref_y_reg);
    assign sq_x      = dx * dx;
    assign sq_y      = dy * dy;
    assign dist_sq   = DW'($unsigned(sq_x)) + DW'($unsigned(sq_y));
    assign limit_ext = DW'({limit_sq, {(2 * SF){1'b0}}});
    assign keep      = (dist_sq <= limit_ext);

    always_comb
    begin
        emit       = 1'b0;
        x_sel      = tag_out.p0x;
        y_sel      = tag_out.p0y;
        last_sel   = 1'b0;
        ref_x_next = ref_x_reg;
        ref_y_next = ref_y_reg;
        if (tag_out.valid)
        begin
            unique case (tag_out.kind)
                bzs_pkg::TOK_START:
                begin
                    emit       = 1'b1;
                    ref_x_next = {tag_out.p0x, {SF{1'b0}}};
                    ref_y_next = {tag_out.p0y, {SF{1'b0}}};
                end
                bzs_pkg::TOK_SAMPLE:
                begin
                    emit  = keep;
                    x_sel = to_coord(sample_x);
                    y_sel = to_coord(sample_y);
                    if (keep)
                    begin
                        ref_x_next = sample_x;
                        ref_y_next = sample_y;
                    end
                end
                bzs_pkg::TOK_END:
                begin
                    emit     = 1'b1;
                    x_sel    = tag_out.p3x;
                    y_sel    = tag_out.p3y;
                    last_sel = 1'b1;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ref_x_reg     <= '0;
            ref_y_reg     <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= emit;
            ref_x_reg     <= ref_x_next;
            ref_y_reg     <= ref_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            point_x_reg <= x_sel;
            point_y_reg <= y_sel;
            last_reg    <= last_sel;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign last      = last_reg;

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= K_W'(LAST_K))
        else $error("step counter beyond end token");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < REM_W'(STEPS))
        else $error("t remainder not reduced");

    a_t_final: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && (kind == bzs_pkg::TOK_SAMPLE) && (k_reg == K_W'(STEPS)))
        |-> (t_reg == bzs_pkg::T_ONE))
        else $error("final sample not at t = 1");

endmodule

// File: hw/rtl/cubic_bezier_sampler.sv
// top level of the cubic bezier sampler
//
//  channel   direction  handshake              beat contents
//  cfg       in         cfg_wen                cfg_wdata = max_step
//  in        in         in_valid / in_stall    start, ctrl1, ctrl2, end points
//  out       out        out_valid / out_stall  point_x, point_y, last
//
// one curve is walked by the back end as STEPS + 2 tokens, one token a cycle
//   unless out_stall holds it: the start point, STEPS grid samples and the end
//   point, issued by the step sequencer; with the back end idle, a taken curve
//   beat is queued and its start point reaches the output register via the tag stages
// rst_n is asynchronous and active low; max_step comes back as 10
// a curve queue of QUEUE_DEPTH entries, two by default, lets the front take the next curves while the back
//   is busy; in_stall rises only when that queue is full
// out_stall holds the whole back pipeline, evaluation lanes included, while a
//   point waits in the output register
module cubic_bezier_sampler
#(
    parameter int STEPS       = bzs_pkg::STEPS_DEFAULT,
    parameter int QUEUE_DEPTH = bzs_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [bzs_pkg::STEP_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bzs_pkg::coord_t               start_x,
    input  bzs_pkg::coord_t               start_y,
    input  bzs_pkg::coord_t               ctrl1_x,
    input  bzs_pkg::coord_t               ctrl1_y,
    input  bzs_pkg::coord_t               ctrl2_x,
    input  bzs_pkg::coord_t               ctrl2_y,
    input  bzs_pkg::coord_t               end_x,
    input  bzs_pkg::coord_t               end_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bzs_pkg::coord_t               point_x,
    output bzs_pkg::coord_t               point_y,
    output logic                          last
);

    localparam int LW = bzs_pkg::LIMIT_W;

    // max_step is held squared, ready for the distance compare
    logic [LW-1:0]          limit_sq_reg, limit_sq_next;
    logic                   push;
    logic                   pop;
    bzs_pkg::curve_t        front_curve;
    bzs_pkg::curve_t        head_curve;
    bzs_pkg::queue_status_t q_status;

    assign limit_sq_next = LW'(cfg_wdata) * LW'(cfg_wdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_sq_reg <= bzs_pkg::LIMIT_SQ_RESET;
        end
        else if (cfg_wen)
        begin
            limit_sq_reg <= limit_sq_next;
        end
    end

    // front: coefficient set-up of each accepted curve
    bzs_front u_front
    (
        .in_valid (in_valid),
        .start_x  (start_x),
        .start_y  (start_y),
        .ctrl1_x  (ctrl1_x),
        .ctrl1_y  (ctrl1_y),
        .ctrl2_x  (ctrl2_x),
        .ctrl2_y  (ctrl2_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .q_status (q_status),
        .in_stall (in_stall),
        .push     (push),
        .curve    (front_curve)
    );

    // queue decouples the two halves
    bzs_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_curve),
        .pop     (pop),
        .rd_data (head_curve),
        .status  (q_status)
    );

    // back: grid walk, evaluation, distance filter, output register
    bzs_back
    #(
        .STEPS (STEPS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_curve),
        .q_status  (q_status),
        .pop       (pop),
        .limit_sq  (limit_sq_reg),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .point_x   (point_x),
        .point_y   (point_y),
        .last      (last)
    );

endmodule
